// ===== hdl/gfr_pkg.sv =====
// package: shared types, codes, defaults and the 5x7 font rom for the glyph renderer
`default_nettype none

package gfr_pkg;

    localparam int DEF_PANEL_WIDTH  = 128;
    localparam int DEF_PANEL_HEIGHT = 64;

    localparam logic [7:0] FIRST_CODE = 8'd32;
    localparam logic [7:0] LAST_CODE  = 8'd90;
    localparam int GLYPH_COLS  = 5;
    localparam int FONT_GLYPHS = 59;
    localparam int QDEPTH      = 2;

    localparam logic [1:0] ACT_DRAW  = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    typedef enum logic [1:0] {
        OP_DRAW,
        OP_CLEAR,
        OP_READ
    } t_op;

    typedef enum logic [2:0] {
        BS_INIT,
        BS_IDLE,
        BS_CLEAR,
        BS_DRAW,
        BS_READ
    } t_bstate;

    // one queued command; page/col give the first byte touched
    typedef struct packed {
        t_op        op;
        logic [5:0] glyph;
        logic [6:0] col;
        logic [3:0] page;
        logic [2:0] shift;
        logic       two_pages;
        logic       read_ok;
    } t_cmd;

    typedef struct packed {
        logic init_busy;
    } t_bk_status;

    // columns left to right, leftmost column in the top byte
    localparam logic [39:0] FONT_ROM [FONT_GLYPHS] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649562050, 40'h0008070300,
        40'h001C224100, 40'h0041221C00, 40'h2A1C7F1C2A, 40'h08083E0808,
        40'h0080703000, 40'h0808080808, 40'h0000606000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h7249494946, 40'h2141494D33,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494931, 40'h4121110907,
        40'h3649494936, 40'h464949291E, 40'h0000140000, 40'h0040340000,
        40'h0008142241, 40'h1414141414, 40'h0041221408, 40'h0201590906,
        40'h3E415D594E, 40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141413E, 40'h7F49494941, 40'h7F09090901, 40'h3E41415173,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F021C027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h2649494932,
        40'h03017F0103, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
        40'h6314081463, 40'h0304780403, 40'h6159494D43
    };

    function automatic logic [7:0] gfr_font(input logic [5:0] idx, input logic [2:0] col);
        logic [39:0] row;
        row = FONT_ROM[idx];
        case (col)
            3'd0:    gfr_font = row[39:32];
            3'd1:    gfr_font = row[31:24];
            3'd2:    gfr_font = row[23:16];
            3'd3:    gfr_font = row[15:8];
            default: gfr_font = row[7:0];
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== hdl/gfr_if.sv =====
// interfaces: command channel and byte result channel
`default_nettype none

interface gfr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] char_code;
    logic [6:0] pos_x;
    logic [5:0] pos_y;
    logic [2:0] read_page;
    logic [6:0] read_column;

    modport source (output valid, action, char_code, pos_x, pos_y, read_page, read_column,
                    input ready);
    modport sink   (input valid, action, char_code, pos_x, pos_y, read_page, read_column,
                    output ready);
endinterface

interface gfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;

    modport source (output valid, pixel_byte, input ready);
    modport sink   (input valid, pixel_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/gfr_front.sv =====
// front end: accepts command beats, drops no-op ones, builds queue commands
`default_nettype none

module gfr_front import gfr_pkg::*; #(
    parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
    gfr_in_if.sink     i_in,
    input  t_bk_status i_status,
    input  logic       i_q_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    localparam int PAGES = PANEL_HEIGHT / 8;

    logic       code_ok;
    logic       x_ok;
    logic       page_ok;
    logic       hi_ok;
    logic       rd_ok;
    logic       keep;
    logic [4:0] page0;

    always_comb begin
        code_ok = i_in.char_code inside {[FIRST_CODE:LAST_CODE]};
        x_ok    = 9'(i_in.pos_x) < 9'(PANEL_WIDTH - GLYPH_COLS);
        page0   = {2'b00, i_in.pos_y[5:3]};
        page_ok = page0 < 5'(PAGES);
        // glyph rows spill into the next page when the row offset is two or more
        hi_ok   = (i_in.pos_y[2:0] >= 3'd2) && ((page0 + 5'd1) < 5'(PAGES));
        rd_ok   = ({2'b00, i_in.read_page} < 5'(PAGES))
                  && (9'(i_in.read_column) < 9'(PANEL_WIDTH));

        i_in.ready = !i_status.init_busy && !i_q_full;

        o_cmd.glyph     = 6'(i_in.char_code - FIRST_CODE);
        o_cmd.shift     = i_in.pos_y[2:0];
        o_cmd.two_pages = hi_ok;
        o_cmd.read_ok   = rd_ok;
        o_cmd.col       = i_in.pos_x;
        o_cmd.page      = {1'b0, i_in.pos_y[5:3]};
        o_cmd.op        = OP_DRAW;
        keep            = 1'b0;

        case (i_in.action)
            ACT_DRAW: begin
                keep = code_ok && x_ok && page_ok;
            end
            ACT_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                keep     = 1'b1;
            end
            ACT_READ: begin
                o_cmd.op   = OP_READ;
                o_cmd.col  = i_in.read_column;
                o_cmd.page = {1'b0, i_in.read_page};
                keep       = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase

        o_push = i_in.valid && i_in.ready && keep;
    end

endmodule

`default_nettype wire

// ===== hdl/gfr_queue.sv =====
// command queue between front and back end
`default_nettype none

module gfr_queue import gfr_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    localparam int PW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    t_cmd          r_slot [QDEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != CW'(QDEPTH)))
        else $error("queue pushed while full");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QDEPTH))
        else $error("queue count past depth");

endmodule

`default_nettype wire

// ===== hdl/gfr_back.sv =====
// back end: framebuffer memory, clear sweep, glyph read-modify-write, byte readout
`default_nettype none

module gfr_back import gfr_pkg::*; #(
    parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  logic       i_q_valid,
    input  t_cmd       i_q_cmd,
    output logic       o_q_pop,
    output t_bk_status o_status,
    gfr_out_if.source  o_out
);

    localparam int PAGES       = PANEL_HEIGHT / 8;
    localparam int STORE_BYTES = PANEL_WIDTH * PAGES;
    localparam int AW          = $clog2(STORE_BYTES);

    t_bstate r_state, n_state;

    logic [7:0]    r_mem [STORE_BYTES];
    logic [7:0]    r_rdata;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_wdata;

    t_cmd          r_cmd, n_cmd;
    logic [AW-1:0] r_addr, n_addr;
    logic [2:0]    r_col, n_col;
    logic          r_half, n_half;
    logic          r_issue, n_issue;
    logic          r_pend, n_pend;
    logic [2:0]    r_pend_col, n_pend_col;
    logic          r_pend_half, n_pend_half;
    logic [AW-1:0] r_pend_addr, n_pend_addr;
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_out_byte, n_out_byte;

    logic [AW-1:0] issue_addr;
    logic [AW-1:0] head_addr;
    logic [7:0]    glyph_col;
    logic [14:0]   wide_d;
    logic [14:0]   wide_m;
    logic [7:0]    byte_d;
    logic [7:0]    byte_m;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_issue     <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_addr      <= n_addr;
            r_issue     <= n_issue;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_col       <= n_col;
        r_half      <= n_half;
        r_pend_col  <= n_pend_col;
        r_pend_half <= n_pend_half;
        r_pend_addr <= n_pend_addr;
        r_out_byte  <= n_out_byte;
    end

    always_comb begin
        issue_addr = AW'(int'(r_cmd.page + 4'(r_half)) * PANEL_WIDTH
                         + int'(r_cmd.col + 7'(r_col)));
        head_addr  = AW'(int'(i_q_cmd.page) * PANEL_WIDTH + int'(i_q_cmd.col));

        // glyph column shifted to its row offset; low byte first page, high byte next page
        glyph_col = gfr_font(r_cmd.glyph, r_pend_col);
        wide_d    = {8'h00, glyph_col[6:0]} << r_cmd.shift;
        wide_m    = 15'h007F << r_cmd.shift;
        byte_d    = r_pend_half ? {1'b0, wide_d[14:8]} : wide_d[7:0];
        byte_m    = r_pend_half ? {1'b0, wide_m[14:8]} : wide_m[7:0];

        n_state     = r_state;
        n_cmd       = r_cmd;
        n_addr      = r_addr;
        n_col       = r_col;
        n_half      = r_half;
        n_issue     = r_issue;
        n_pend      = 1'b0;
        n_pend_col  = r_pend_col;
        n_pend_half = r_pend_half;
        n_pend_addr = r_pend_addr;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_byte  = r_out_byte;
        o_q_pop     = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_addr;
        mem_wdata   = 8'h00;
        mem_re      = 1'b0;
        mem_raddr   = issue_addr;

        case (r_state)
            BS_INIT, BS_CLEAR: begin
                mem_we = 1'b1;
                if (r_addr == AW'(STORE_BYTES - 1)) begin
                    n_addr  = '0;
                    n_state = BS_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            BS_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    case (i_q_cmd.op)
                        OP_CLEAR: begin
                            n_addr  = '0;
                            n_state = BS_CLEAR;
                        end
                        OP_DRAW: begin
                            n_col   = 3'd0;
                            n_half  = 1'b0;
                            n_issue = 1'b1;
                            n_state = BS_DRAW;
                        end
                        OP_READ: begin
                            mem_re    = i_q_cmd.read_ok;
                            mem_raddr = head_addr;
                            n_state   = BS_READ;
                        end
                        default: begin
                            n_state = BS_IDLE;
                        end
                    endcase
                end
            end
            BS_DRAW: begin
                // read of the next byte overlaps the write of the previous one
                if (r_issue) begin
                    mem_re      = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_col  = r_col;
                    n_pend_half = r_half;
                    n_pend_addr = issue_addr;
                    if (!r_half && r_cmd.two_pages) begin
                        n_half = 1'b1;
                    end else if (r_col == 3'(GLYPH_COLS - 1)) begin
                        n_issue = 1'b0;
                    end else begin
                        n_col  = r_col + 3'd1;
                        n_half = 1'b0;
                    end
                end
                if (r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pend_addr;
                    mem_wdata = (r_rdata & ~byte_m) | (byte_d & byte_m);
                end
                if (!r_issue && !r_pend) begin
                    n_state = BS_IDLE;
                end
            end
            BS_READ: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_cmd.read_ok ? r_rdata : 8'h00;
                    n_state     = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    assign o_status.init_busy = (r_state == BS_INIT);
    assign o_out.valid        = r_out_valid;
    assign o_out.pixel_byte   = r_out_byte;

    a_pend_follows_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> ($past(r_issue) && r_state == BS_DRAW))
        else $error("pending write without a preceding read");

    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write hit the same byte");

    a_read_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_READ && n_state == BS_IDLE) |=> r_out_valid)
        else $error("read finished without a result beat");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == BS_IDLE && i_q_valid))
        else $error("command taken outside idle");

endmodule

`default_nettype wire

// ===== hdl/glyph_to_framebuffer_renderer_core.sv =====
// top level: 5x7 glyph renderer into a page-organized monochrome framebuffer
//
//  channel  | dir | payload                                              | accepted when
//  ---------+-----+------------------------------------------------------+--------------------
//  i_in     | in  | action, char_code, pos_x, pos_y, read_page, read_col | valid && ready
//  o_out    | out | pixel_byte (one beat per read command)               | valid && ready
//
// after reset the framebuffer is swept to zero, one byte a cycle, all PANEL_WIDTH*PANEL_HEIGHT/8
//   bytes (1024 at 128x64); i_in.ready stays low for the whole sweep
// a draw holds the back end through the pop, one read-modify-write per touched byte (5 or 10)
//   with each read overlapped on the previous write, the last write, and a final retiring step
// a read pops and reads its byte, then waits while an earlier byte still waits on o_out
// a clear sweeps all PANEL_WIDTH*PANEL_HEIGHT/8 bytes to zero after the pop
// a two-entry command queue lets new beats enter while the back end works or o_out stalls
`default_nettype none

module glyph_to_framebuffer_renderer_core import gfr_pkg::*; #(
    parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    gfr_in_if.sink    i_in,
    gfr_out_if.source o_out
);

    // front to queue
    logic       push;
    t_cmd       push_cmd;
    logic       q_full;

    // queue to back end
    logic       q_valid;
    t_cmd       q_cmd;
    logic       q_pop;

    // back end holds off the front during the power-up sweep
    t_bk_status bk_status;

    gfr_front #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_front (
        .i_in     (i_in),
        .i_status (bk_status),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    gfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    gfr_back #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (q_pop),
        .o_status  (bk_status),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire
